/* hdl/fmpa_pkg.sv */
// Shared types and constants of the fractional max pool argmax block.
package fmpa_pkg;

    localparam int OP_W        = 2;
    localparam int SIZE_W      = 11;
    localparam int DIM_W       = 11;
    localparam int CNT_REG_W   = 7;
    localparam int PLANE_W     = 16;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PIXEL    = 2'd0,
        OP_ROW_SIZE = 2'd1,
        OP_COL_SIZE = 2'd2
    } fmpa_op_t;

    typedef enum logic [ADDR_W-3:0] {
        REG_IMAGE_WIDTH      = 3'd0,
        REG_IMAGE_HEIGHT     = 3'd1,
        REG_ROW_WINDOW_COUNT = 3'd2,
        REG_COL_WINDOW_COUNT = 3'd3,
        REG_PLANE_COUNT      = 3'd4
    } fmpa_reg_t;

    typedef struct packed {
        logic [DIM_W-1:0]     image_width;
        logic [DIM_W-1:0]     image_height;
        logic [CNT_REG_W-1:0] row_window_count;
        logic [CNT_REG_W-1:0] col_window_count;
        logic [PLANE_W-1:0]   plane_count;
    } fmpa_cfg_t;

    typedef struct packed {
        logic corner;
        logic emit;
        logic last_plane;
        logic last_job;
    } fmpa_flags_t;

endpackage

/* hdl/fmpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fmpa_ram
    import fmpa_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/fmpa_fifo.sv */
// Small register FIFO used between the front and back and on the result side.
module fmpa_fifo
    import fmpa_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty,
    output logic [CW-1:0]    count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* hdl/fmpa_front.sv */
// Front end: size tables, raster position tracking and window classification of pixels.
module fmpa_front
    import fmpa_pkg::*;
#(
    parameter int MAX_DIM     = 1024,
    parameter int MAX_WINDOWS = 64,
    parameter int VALUE_WIDTH = 32,
    localparam int POS_W = $clog2(MAX_DIM),
    localparam int XW    = POS_W + 1,
    localparam int WIN_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1,
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1),
    localparam int EW    = ((XW > SIZE_W) ? XW : SIZE_W) + 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  fmpa_cfg_t              cfg,
    input  logic                   push,
    input  logic [OP_W-1:0]        op,
    input  logic [WIN_W-1:0]       table_index,
    input  logic [SIZE_W-1:0]      window_size,
    input  logic [VALUE_WIDTH-1:0] pixel_value,
    input  logic                   q_full,
    output logic                   q_push,
    output logic [WIN_W-1:0]       q_slot,
    output logic [WIN_W-1:0]       q_wrow,
    output logic [POS_W-1:0]       q_row,
    output logic [POS_W-1:0]       q_col,
    output logic [VALUE_WIDTH-1:0] q_value,
    output fmpa_flags_t            q_flags
);

    logic [POS_W-1:0]   pixel_row_reg, pixel_row_next;
    logic [POS_W-1:0]   pixel_col_reg, pixel_col_next;
    logic [CNT_W-1:0]   row_idx_reg, row_idx_next;
    logic [XW-1:0]      row_start_reg, row_start_next;
    logic [CNT_W-1:0]   col_idx_reg, col_idx_next;
    logic [XW-1:0]      col_start_reg, col_start_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;
    logic               row_byp_reg, row_byp_next;
    logic               col_byp_reg, col_byp_next;
    logic [SIZE_W-1:0]  row_byp_data_reg, col_byp_data_reg;

    logic               accept, is_pix, idx_ok, row_wr, col_wr;
    logic [XW-1:0]      w, h;
    logic [CNT_W-1:0]   rc, cc;
    logic [PLANE_W-1:0] np;
    logic [SIZE_W-1:0]  row_rd, col_rd, row_size, col_size;
    logic [EW-1:0]      row_e, col_e, row_lim, col_lim;
    logic [POS_W-1:0]   rend, cend;
    logic               row_act, col_act, lp, plane_done;

    assign accept = push && !q_full;
    assign is_pix = accept && (op == OP_PIXEL);
    assign idx_ok = 32'(table_index) < MAX_WINDOWS;
    assign row_wr = accept && (op == OP_ROW_SIZE) && idx_ok;
    assign col_wr = accept && (op == OP_COL_SIZE) && idx_ok;

    always_comb
    begin
        if (cfg.image_width == '0)
            w = XW'(1);
        else if (32'(cfg.image_width) > MAX_DIM)
            w = XW'(MAX_DIM);
        else
            w = XW'(cfg.image_width);
        if (cfg.image_height == '0)
            h = XW'(1);
        else if (32'(cfg.image_height) > MAX_DIM)
            h = XW'(MAX_DIM);
        else
            h = XW'(cfg.image_height);
        if (cfg.row_window_count == '0)
            rc = CNT_W'(1);
        else if (32'(cfg.row_window_count) > MAX_WINDOWS)
            rc = CNT_W'(MAX_WINDOWS);
        else
            rc = CNT_W'(cfg.row_window_count);
        if (cfg.col_window_count == '0)
            cc = CNT_W'(1);
        else if (32'(cfg.col_window_count) > MAX_WINDOWS)
            cc = CNT_W'(MAX_WINDOWS);
        else
            cc = CNT_W'(cfg.col_window_count);
        np = (cfg.plane_count == '0) ? PLANE_W'(1) : cfg.plane_count;
    end

    fmpa_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_WINDOWS)) u_row_table (
        .clk   (clk),
        .we    (row_wr),
        .waddr (table_index),
        .wdata (window_size),
        .raddr (row_idx_next[WIN_W-1:0]),
        .rdata (row_rd)
    );

    fmpa_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_WINDOWS)) u_col_table (
        .clk   (clk),
        .we    (col_wr),
        .waddr (table_index),
        .wdata (window_size),
        .raddr (col_idx_next[WIN_W-1:0]),
        .rdata (col_rd)
    );

    assign row_byp_next = row_wr && (table_index == row_idx_next[WIN_W-1:0]);
    assign col_byp_next = col_wr && (table_index == col_idx_next[WIN_W-1:0]);

    always_comb
    begin
        row_size = row_byp_reg ? row_byp_data_reg : row_rd;
        col_size = col_byp_reg ? col_byp_data_reg : col_rd;
        if (row_size == '0)
            row_size = SIZE_W'(1);
        if (col_size == '0)
            col_size = SIZE_W'(1);
        row_e   = EW'(row_start_reg) + EW'(row_size);
        col_e   = EW'(col_start_reg) + EW'(col_size);
        row_lim = (row_e > EW'(h)) ? EW'(h) : row_e;
        col_lim = (col_e > EW'(w)) ? EW'(w) : col_e;
        rend    = POS_W'(row_lim - EW'(1));
        cend    = POS_W'(col_lim - EW'(1));
    end

    assign row_act = (row_idx_reg < rc) && (row_start_reg < h);
    assign col_act = (col_idx_reg < cc) && (col_start_reg < w);
    assign lp = ((row_idx_reg == rc - CNT_W'(1)) || (XW'(rend) == h - XW'(1))) &&
                ((col_idx_reg == cc - CNT_W'(1)) || (XW'(cend) == w - XW'(1)));
    assign plane_done = (17'(plane_reg) + 17'd1) >= 17'(np);

    assign q_push             = is_pix && row_act && col_act;
    assign q_slot             = col_idx_reg[WIN_W-1:0];
    assign q_wrow             = row_idx_reg[WIN_W-1:0];
    assign q_row              = pixel_row_reg;
    assign q_col              = pixel_col_reg;
    assign q_value            = pixel_value;
    assign q_flags.corner     = (XW'(pixel_row_reg) == row_start_reg) &&
                                (XW'(pixel_col_reg) == col_start_reg);
    assign q_flags.emit       = (pixel_row_reg >= rend) && (pixel_col_reg >= cend);
    assign q_flags.last_plane = lp;
    assign q_flags.last_job   = lp && plane_done;

    always_comb
    begin
        pixel_row_next = pixel_row_reg;
        pixel_col_next = pixel_col_reg;
        row_idx_next   = row_idx_reg;
        row_start_next = row_start_reg;
        col_idx_next   = col_idx_reg;
        col_start_next = col_start_reg;
        plane_next     = plane_reg;
        if (is_pix)
        begin
            if (col_act && (pixel_col_reg >= cend))
            begin
                col_idx_next   = col_idx_reg + CNT_W'(1);
                col_start_next = XW'(cend) + XW'(1);
            end
            if (XW'(pixel_col_reg) >= w - XW'(1))
            begin
                pixel_col_next = '0;
                col_idx_next   = '0;
                col_start_next = '0;
                if (row_act && (pixel_row_reg >= rend))
                begin
                    row_idx_next   = row_idx_reg + CNT_W'(1);
                    row_start_next = XW'(rend) + XW'(1);
                end
                if (XW'(pixel_row_reg) >= h - XW'(1))
                begin
                    pixel_row_next = '0;
                    row_idx_next   = '0;
                    row_start_next = '0;
                    plane_next     = plane_done ? '0 : plane_reg + PLANE_W'(1);
                end
                else
                begin
                    pixel_row_next = pixel_row_reg + POS_W'(1);
                end
            end
            else
            begin
                pixel_col_next = pixel_col_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_row_reg <= '0;
            pixel_col_reg <= '0;
            row_idx_reg   <= '0;
            row_start_reg <= '0;
            col_idx_reg   <= '0;
            col_start_reg <= '0;
            plane_reg     <= '0;
            row_byp_reg   <= 1'b0;
            col_byp_reg   <= 1'b0;
        end
        else
        begin
            pixel_row_reg <= pixel_row_next;
            pixel_col_reg <= pixel_col_next;
            row_idx_reg   <= row_idx_next;
            row_start_reg <= row_start_next;
            col_idx_reg   <= col_idx_next;
            col_start_reg <= col_start_next;
            plane_reg     <= plane_next;
            row_byp_reg   <= row_byp_next;
            col_byp_reg   <= col_byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_byp_data_reg <= window_size;
        col_byp_data_reg <= window_size;
    end

endmodule

/* hdl/fmpa_back.sv */
// Back end: per-column best tracking with read-modify-write and the result queue.
module fmpa_back
    import fmpa_pkg::*;
#(
    parameter int MAX_DIM     = 1024,
    parameter int MAX_WINDOWS = 64,
    parameter int VALUE_WIDTH = 32,
    localparam int POS_W   = $clog2(MAX_DIM),
    localparam int WIN_W   = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1,
    localparam int ENTRY_W = VALUE_WIDTH + 2 * POS_W + 1,
    localparam int OUT_W   = 2 * WIN_W + 2 * POS_W + VALUE_WIDTH + 2,
    localparam int QCW     = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [WIN_W-1:0]       in_slot,
    input  logic [WIN_W-1:0]       in_wrow,
    input  logic [POS_W-1:0]       in_row,
    input  logic [POS_W-1:0]       in_col,
    input  logic [VALUE_WIDTH-1:0] in_value,
    input  fmpa_flags_t            in_flags,
    output logic                   in_pop,
    input  logic                   pop,
    output logic                   empty,
    output logic [WIN_W-1:0]       window_row,
    output logic [WIN_W-1:0]       window_col,
    output logic [POS_W-1:0]       max_row,
    output logic [POS_W-1:0]       max_col,
    output logic [VALUE_WIDTH-1:0] max_value,
    output logic                   last_of_plane,
    output logic                   last_of_job
);

    logic                   b_valid_reg;
    logic [WIN_W-1:0]       b_slot_reg, b_wrow_reg;
    logic [POS_W-1:0]       b_row_reg, b_col_reg;
    logic [VALUE_WIDTH-1:0] b_value_reg;
    fmpa_flags_t            b_flags_reg;
    logic                   byp_hit_reg, byp_hit_next;
    logic [ENTRY_W-1:0]     byp_entry_reg;

    logic [ENTRY_W-1:0]     rd_entry, cur_entry, new_entry;
    logic [VALUE_WIDTH-1:0] cur_value;
    logic [POS_W-1:0]       cur_row, cur_col;
    logic                   cur_corner, take, new_corner;
    logic [QCW-1:0]         out_count;
    logic                   out_full;
    logic [OUT_W-1:0]       out_wdata, out_rdata;
    logic [QCW:0]           occupancy;

    assign occupancy    = (QCW + 1)'(out_count) + (QCW + 1)'(b_valid_reg);
    assign in_pop       = in_valid && (occupancy < (QCW + 1)'(QUEUE_DEPTH));
    assign byp_hit_next = in_pop && b_valid_reg && (in_slot == b_slot_reg);

    fmpa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WINDOWS)) u_best (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_slot_reg),
        .wdata (new_entry),
        .raddr (in_slot),
        .rdata (rd_entry)
    );

    always_comb
    begin
        cur_entry = byp_hit_reg ? byp_entry_reg : rd_entry;
        {cur_value, cur_row, cur_col, cur_corner} = cur_entry;
        if (cur_corner)
            take = $signed(b_value_reg) > $signed(cur_value);
        else
            take = $signed(b_value_reg) >= $signed(cur_value);
        if (b_flags_reg.corner)
        begin
            new_corner = 1'b1;
            new_entry  = {b_value_reg, b_row_reg, b_col_reg, new_corner};
        end
        else if (take)
        begin
            new_corner = 1'b0;
            new_entry  = {b_value_reg, b_row_reg, b_col_reg, new_corner};
        end
        else
        begin
            new_corner = cur_corner;
            new_entry  = {cur_value, cur_row, cur_col, new_corner};
        end
    end

    assign out_wdata = {b_wrow_reg, b_slot_reg, new_entry[ENTRY_W-1:1],
                        b_flags_reg.last_plane, b_flags_reg.last_job};

    fmpa_fifo #(.WIDTH(OUT_W), .DEPTH(QUEUE_DEPTH)) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (b_valid_reg && b_flags_reg.emit),
        .wdata (out_wdata),
        .pop   (pop),
        .rdata (out_rdata),
        .full  (out_full),
        .empty (empty),
        .count (out_count)
    );

    assign {window_row, window_col, max_value, max_row, max_col,
            last_of_plane, last_of_job} = out_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= in_pop;
            byp_hit_reg <= byp_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_pop)
        begin
            b_slot_reg  <= in_slot;
            b_wrow_reg  <= in_wrow;
            b_row_reg   <= in_row;
            b_col_reg   <= in_col;
            b_value_reg <= in_value;
            b_flags_reg <= in_flags;
        end
        byp_entry_reg <= new_entry;
    end

    // A full result queue never reaches the push side: admission accounts for stage B.
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_flags_reg.emit) |-> !out_full)
        else $error("result queue overrun");

endmodule

/* hdl/fractional_max_pool_argmax_2d_core.sv */
// Top level of the fractional max pool argmax block: register port, front, queue and back.
//
// Pixels stream in raster order, plane after plane, and are pooled over a grid of
// variable-sized windows whose row and column extents are loaded as table items
// (op 1 and op 2). One result per window gives the position and value of its
// maximum; it is pushed into the result queue from stage B of the back once the
// window's bottom-right pixel gets there. The block takes one item per clock: the
// front classifies each pixel combinationally against the size tables, and the
// back updates the per-column best entry with a read-modify-write on its memory
// that forwards the previous update, so pixels of the same window may follow one
// another in every cycle. Input stalls only when the result queue backs up through
// the four-entry queue between the two parts.
module fractional_max_pool_argmax_2d_core
    import fmpa_pkg::*;
#(
    parameter int MAX_DIM     = 1024,
    parameter int MAX_WINDOWS = 64,
    parameter int VALUE_WIDTH = 32,
    localparam int POS_W = $clog2(MAX_DIM),
    localparam int WIN_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    input  logic                   push,
    output logic                   full,
    input  logic [OP_W-1:0]        op,
    input  logic [WIN_W-1:0]       table_index,
    input  logic [SIZE_W-1:0]      window_size,
    input  logic [VALUE_WIDTH-1:0] pixel_value,
    output logic                   empty,
    input  logic                   pop,
    output logic [WIN_W-1:0]       window_row,
    output logic [WIN_W-1:0]       window_col,
    output logic [POS_W-1:0]       max_row,
    output logic [POS_W-1:0]       max_col,
    output logic [VALUE_WIDTH-1:0] max_value,
    output logic                   last_of_plane,
    output logic                   last_of_job
);

    localparam int FLAGS_W = $bits(fmpa_flags_t);
    localparam int MID_W   = 2 * WIN_W + 2 * POS_W + VALUE_WIDTH + FLAGS_W;
    localparam int QCW     = $clog2(QUEUE_DEPTH + 1);

    fmpa_cfg_t              cfg_reg, cfg_next;
    fmpa_reg_t              reg_sel;
    logic                   cfg_wr;

    logic                   mid_push, mid_pop, mid_full, mid_empty;
    logic [QCW-1:0]         mid_count;
    logic [MID_W-1:0]       mid_wdata, mid_rdata;
    logic [WIN_W-1:0]       f_slot, f_wrow, m_slot, m_wrow;
    logic [POS_W-1:0]       f_row, f_col, m_row, m_col;
    logic [VALUE_WIDTH-1:0] f_value, m_value;
    fmpa_flags_t            f_flags, m_flags;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = fmpa_reg_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        case (reg_sel)
            REG_IMAGE_WIDTH:
            begin
                prdata = DATA_W'(cfg_reg.image_width);
                if (cfg_wr)
                    cfg_next.image_width = pwdata[DIM_W-1:0];
            end
            REG_IMAGE_HEIGHT:
            begin
                prdata = DATA_W'(cfg_reg.image_height);
                if (cfg_wr)
                    cfg_next.image_height = pwdata[DIM_W-1:0];
            end
            REG_ROW_WINDOW_COUNT:
            begin
                prdata = DATA_W'(cfg_reg.row_window_count);
                if (cfg_wr)
                    cfg_next.row_window_count = pwdata[CNT_REG_W-1:0];
            end
            REG_COL_WINDOW_COUNT:
            begin
                prdata = DATA_W'(cfg_reg.col_window_count);
                if (cfg_wr)
                    cfg_next.col_window_count = pwdata[CNT_REG_W-1:0];
            end
            REG_PLANE_COUNT:
            begin
                prdata = DATA_W'(cfg_reg.plane_count);
                if (cfg_wr)
                    cfg_next.plane_count = pwdata[PLANE_W-1:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width      <= DIM_W'(1024);
            cfg_reg.image_height     <= DIM_W'(1024);
            cfg_reg.row_window_count <= CNT_REG_W'(1);
            cfg_reg.col_window_count <= CNT_REG_W'(1);
            cfg_reg.plane_count      <= PLANE_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fmpa_front #(
        .MAX_DIM     (MAX_DIM),
        .MAX_WINDOWS (MAX_WINDOWS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .op          (op),
        .table_index (table_index),
        .window_size (window_size),
        .pixel_value (pixel_value),
        .q_full      (mid_full),
        .q_push      (mid_push),
        .q_slot      (f_slot),
        .q_wrow      (f_wrow),
        .q_row       (f_row),
        .q_col       (f_col),
        .q_value     (f_value),
        .q_flags     (f_flags)
    );

    assign full      = mid_full;
    assign mid_wdata = {f_slot, f_wrow, f_row, f_col, f_value, f_flags};

    fmpa_fifo #(.WIDTH(MID_W), .DEPTH(QUEUE_DEPTH)) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .full  (mid_full),
        .empty (mid_empty),
        .count (mid_count)
    );

    assign m_slot  = mid_rdata[MID_W-1 -: WIN_W];
    assign m_wrow  = mid_rdata[MID_W-WIN_W-1 -: WIN_W];
    assign m_row   = mid_rdata[MID_W-2*WIN_W-1 -: POS_W];
    assign m_col   = mid_rdata[MID_W-2*WIN_W-POS_W-1 -: POS_W];
    assign m_value = mid_rdata[FLAGS_W+VALUE_WIDTH-1 -: VALUE_WIDTH];
    assign m_flags = fmpa_flags_t'(mid_rdata[FLAGS_W-1:0]);

    fmpa_back #(
        .MAX_DIM     (MAX_DIM),
        .MAX_WINDOWS (MAX_WINDOWS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (!mid_empty),
        .in_slot       (m_slot),
        .in_wrow       (m_wrow),
        .in_row        (m_row),
        .in_col        (m_col),
        .in_value      (m_value),
        .in_flags      (m_flags),
        .in_pop        (mid_pop),
        .pop           (pop),
        .empty         (empty),
        .window_row    (window_row),
        .window_col    (window_col),
        .max_row       (max_row),
        .max_col       (max_col),
        .max_value     (max_value),
        .last_of_plane (last_of_plane),
        .last_of_job   (last_of_job)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> !mid_full)
        else $error("pixel request pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && (op != OP_PIXEL)) |-> !mid_push)
        else $error("table load request reached the back end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_of_job) |-> last_of_plane)
        else $error("end of job without end of plane");

    assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |=> (mid_count != QCW'(QUEUE_DEPTH)) || $past(mid_push))
        else $error("queue count inconsistent with drain");

endmodule

/* tb/sv/pool_argmax_checker.sv */
// Checker for the fractional max pool argmax block: predicts window maxima and compares results.
module pool_argmax_checker
    import fmpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    input  logic                 pready,
    input  logic                 push,
    input  logic                 full,
    input  logic [OP_W-1:0]      op,
    input  logic [5:0]           table_index,
    input  logic [SIZE_W-1:0]    window_size,
    input  logic [31:0]          pixel_value,
    input  logic                 pop,
    input  logic                 empty,
    input  logic [5:0]           window_row,
    input  logic [5:0]           window_col,
    input  logic [9:0]           max_row,
    input  logic [9:0]           max_col,
    input  logic [31:0]          max_value,
    input  logic                 last_of_plane,
    input  logic                 last_of_job,
    output int                   fail_count,
    output int                   windows_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DIM_LIMIT = 1024;
    localparam int unsigned WINDOW_LIMIT = 64;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [5:0]  win_row;
        logic [5:0]  win_col;
        logic [9:0]  pos_row;
        logic [9:0]  pos_col;
        logic [31:0] value;
        logic        plane_done;
        logic        job_done;
    } window_max_t;

    window_max_t        expected_windows[$];
    fmpa_cfg_t          cfg;
    logic [SIZE_W-1:0]  row_extent [WINDOW_LIMIT];
    logic [SIZE_W-1:0]  col_extent [WINDOW_LIMIT];
    logic signed [31:0] best_val [WINDOW_LIMIT];
    logic [9:0]         best_r [WINDOW_LIMIT];
    logic [9:0]         best_c [WINDOW_LIMIT];
    logic               best_corner [WINDOW_LIMIT];
    int unsigned        pix_row, pix_col, row_win, row_start, col_win, col_start, plane_idx;

    function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned extent_end(int unsigned start, int unsigned size,
                                               int unsigned limit);
        int unsigned stop;
        stop = start + ((size == 0) ? 1 : size);
        return ((stop > limit) ? limit : stop) - 1;
    endfunction

    task automatic reset_pool_state();
        cfg.image_width      = 11'd1024;
        cfg.image_height     = 11'd1024;
        cfg.row_window_count = 7'd1;
        cfg.col_window_count = 7'd1;
        cfg.plane_count      = 16'd1;
        for (int i = 0; i < WINDOW_LIMIT; i++)
        begin
            row_extent[i]  = '0;
            col_extent[i]  = '0;
            best_val[i]    = '0;
            best_r[i]      = '0;
            best_c[i]      = '0;
            best_corner[i] = 1'b0;
        end
        pix_row   = 0;
        pix_col   = 0;
        row_win   = 0;
        row_start = 0;
        col_win   = 0;
        col_start = 0;
        plane_idx = 0;
        expected_windows.delete();
    endtask

    task automatic pool_pixel(logic signed [31:0] raw);
        int unsigned w, h, rc, cc, np, pr, pc, rend, cend, s;
        bit          row_act, col_act, plane_done;
        window_max_t res;
        w  = clamp_to(cfg.image_width, DIM_LIMIT);
        h  = clamp_to(cfg.image_height, DIM_LIMIT);
        rc = clamp_to(cfg.row_window_count, WINDOW_LIMIT);
        cc = clamp_to(cfg.col_window_count, WINDOW_LIMIT);
        np = (cfg.plane_count == 0) ? 1 : cfg.plane_count;
        pr = pix_row;
        pc = pix_col;
        rend = 0;
        cend = 0;
        row_act = (row_win < rc) && (row_start < h);
        col_act = (col_win < cc) && (col_start < w);
        if (row_act)
            rend = extent_end(row_start, row_extent[row_win], h);
        if (col_act)
            cend = extent_end(col_start, col_extent[col_win], w);

        if (row_act && col_act)
        begin
            s = col_win;
            if (pr == row_start && pc == col_start)
            begin
                best_val[s]    = raw;
                best_r[s]      = 10'(pr);
                best_c[s]      = 10'(pc);
                best_corner[s] = 1'b1;
            end
            else if (best_corner[s] ? (raw > best_val[s]) : (raw >= best_val[s]))
            begin
                best_val[s]    = raw;
                best_r[s]      = 10'(pr);
                best_c[s]      = 10'(pc);
                best_corner[s] = 1'b0;
            end
            if (pr >= rend && pc >= cend)
            begin
                plane_done = (row_win == rc - 1 || rend == h - 1) &&
                             (col_win == cc - 1 || cend == w - 1);
                res.win_row    = 6'(row_win);
                res.win_col    = 6'(col_win);
                res.pos_row    = best_r[s];
                res.pos_col    = best_c[s];
                res.value      = best_val[s];
                res.plane_done = plane_done;
                res.job_done   = plane_done && (plane_idx + 1 >= np);
                expected_windows.push_back(res);
            end
        end

        if (col_act && pc >= cend)
        begin
            col_win++;
            col_start = cend + 1;
        end
        if (pc >= w - 1)
        begin
            pix_col   = 0;
            col_win   = 0;
            col_start = 0;
            if (row_act && pr >= rend)
            begin
                row_win++;
                row_start = rend + 1;
            end
            if (pr >= h - 1)
            begin
                pix_row   = 0;
                row_win   = 0;
                row_start = 0;
                plane_idx = (plane_idx + 1 >= np) ? 0 : plane_idx + 1;
            end
            else
            begin
                pix_row = pr + 1;
            end
        end
        else
        begin
            pix_col = pc + 1;
        end
    endtask

    task automatic check_window();
        window_max_t want;
        window_max_t got;
        got = '{window_row, window_col, max_row, max_col, max_value,
                last_of_plane, last_of_job};
        if (expected_windows.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected window result: win %0d,%0d max at %0d,%0d value %0d",
                         got.win_row, got.win_col, got.pos_row, got.pos_col,
                         $signed(got.value));
        end
        else
        begin
            want = expected_windows.pop_front();
            if (got !== want)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("window mismatch expected: win %0d,%0d max at %0d,%0d value %0d last %b%b",
                             want.win_row, want.win_col, want.pos_row, want.pos_col,
                             $signed(want.value), want.plane_done, want.job_done);
                    $display("window mismatch actual:   win %0d,%0d max at %0d,%0d value %0d last %b%b",
                             got.win_row, got.win_col, got.pos_row, got.pos_col,
                             $signed(got.value), got.plane_done, got.job_done);
                end
            end
        end
    endtask

    task automatic write_register();
        case (fmpa_reg_t'(paddr[ADDR_W-1:2]))
            REG_IMAGE_WIDTH:      cfg.image_width      = pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT:     cfg.image_height     = pwdata[DIM_W-1:0];
            REG_ROW_WINDOW_COUNT: cfg.row_window_count = pwdata[CNT_REG_W-1:0];
            REG_COL_WINDOW_COUNT: cfg.col_window_count = pwdata[CNT_REG_W-1:0];
            REG_PLANE_COUNT:      cfg.plane_count      = pwdata[PLANE_W-1:0];
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_pool_state();
        end
        else
        begin
            if (pop && !empty)
                check_window();
            if (push && !full)
            begin
                case (op)
                    OP_PIXEL:    pool_pixel(pixel_value);
                    OP_ROW_SIZE: row_extent[table_index] = window_size;
                    OP_COL_SIZE: col_extent[table_index] = window_size;
                    default: ;
                endcase
            end
            if (psel && penable && pwrite && pready)
                write_register();
        end
        windows_pending = expected_windows.size();
    end

endmodule

/* tb/sv/testbench.sv */
// Top of the fractional max pool argmax testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fmpa_pkg::*;

    localparam logic [OP_W-1:0]  OP_UNUSED    = 2'd3;
    localparam int               ITEM_TARGET  = 1950;
    localparam int               DRAIN_CYCLES = 16;
    localparam logic [31:0]      VALUE_MIN    = 32'h8000_0000;
    localparam logic [31:0]      VALUE_MAX    = 32'h7FFF_FFFF;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              push = 1'b0;
    logic              full;
    logic [OP_W-1:0]   op = OP_PIXEL;
    logic [5:0]        table_index = '0;
    logic [SIZE_W-1:0] window_size = '0;
    logic [31:0]       pixel_value = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [5:0]        window_row;
    logic [5:0]        window_col;
    logic [9:0]        max_row;
    logic [9:0]        max_col;
    logic [31:0]       max_value;
    logic              last_of_plane;
    logic              last_of_job;
    int                fail_count;
    int                windows_pending;
    int                items_sent = 0;
    int                send_idle_pct = 15;
    int                recv_idle_pct = 47;

    fractional_max_pool_argmax_2d_core DUT (.*);

    pool_argmax_checker argmax_check (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    task automatic write_register(fmpa_reg_t which, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_request(logic [OP_W-1:0] kind, logic [5:0] idx,
                                logic [SIZE_W-1:0] size, logic [31:0] value);
        if (items_sent < ITEM_TARGET / 3)
        begin
            send_idle_pct = 15;
            recv_idle_pct = 47;
        end
        else if (items_sent < 2 * ITEM_TARGET / 3)
        begin
            send_idle_pct = 47;
            recv_idle_pct = 15;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push        <= 1'b1;
        op          <= kind;
        table_index <= idx;
        window_size <= size;
        pixel_value <= value;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do
            @(negedge clk);
        while (windows_pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'($urandom_range(6)) - 32'd3;
            4:          return VALUE_MIN;
            5:          return VALUE_MAX;
            6:          return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default:    return $urandom();
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(19))
            0:       return '0;
            1:       return 11'd1024;
            2:       return 11'd2047;
            3:       return SIZE_W'($urandom_range(2047));
            default: return SIZE_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_dim();
        case ($urandom_range(15))
            0:       return 0;
            1:       return 2047;
            2:       return 1024;
            3:       return 1;
            default: return $urandom_range(2, 12);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_count();
        case ($urandom_range(15))
            0:       return 0;
            1:       return 127;
            2:       return 64;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    task automatic configure_job(logic [DATA_W-1:0] w, logic [DATA_W-1:0] h,
                                 logic [DATA_W-1:0] rc, logic [DATA_W-1:0] cc,
                                 logic [DATA_W-1:0] np);
        wait_drained();
        write_register(REG_IMAGE_WIDTH, w);
        write_register(REG_IMAGE_HEIGHT, h);
        write_register(REG_ROW_WINDOW_COUNT, rc);
        write_register(REG_COL_WINDOW_COUNT, cc);
        write_register(REG_PLANE_COUNT, np);
    endtask

    task automatic run_job(int phase);
        logic [DATA_W-1:0] w, h, rc, cc, np;
        int                n;
        int                r;
        case (phase)
            0:
            begin
                w = 2047; h = 0; rc = 127; cc = 0; np = 0;
            end
            1:
            begin
                w = 0; h = 2047; rc = 0; cc = 127; np = 65535;
            end
            default:
            begin
                w  = pick_dim();
                h  = pick_dim();
                rc = pick_count();
                cc = pick_count();
                np = ($urandom_range(9) == 0) ? 65535 :
                     ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
            end
        endcase
        configure_job(w, h, rc, cc, np);
        for (int i = 0; i < ((rc == 0) ? 1 : ((rc > 8) ? 8 : rc)); i++)
            send_request(OP_ROW_SIZE, 6'(i), pick_size(), $urandom());
        for (int i = 0; i < ((cc == 0) ? 1 : ((cc > 8) ? 8 : cc)); i++)
            send_request(OP_COL_SIZE, 6'(i), pick_size(), $urandom());
        n = $urandom_range(60, 220);
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 2)
                send_request(OP_ROW_SIZE, 6'($urandom()), pick_size(), $urandom());
            else if (r < 4)
                send_request(OP_COL_SIZE, 6'($urandom()), pick_size(), $urandom());
            else if (r < 6)
                send_request(OP_UNUSED, 6'($urandom()), SIZE_W'($urandom()), $urandom());
            else
                send_request(OP_PIXEL, 6'($urandom()), SIZE_W'($urandom()), pick_value());
        end
    endtask

    initial
    begin
        int phase;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // load every table entry and touch every column slot once
        configure_job(64, 1, 1, 64, 1);
        for (int i = 0; i < 64; i++)
            send_request(OP_ROW_SIZE, 6'(i), pick_size(), $urandom());
        for (int i = 0; i < 64; i++)
            send_request(OP_COL_SIZE, 6'(i), 11'd1, $urandom());
        repeat (64)
            send_request(OP_PIXEL, 6'($urandom()), SIZE_W'($urandom()), pick_value());

        // clipped and empty windows, corner ties, later ties, value extremes
        configure_job(5, 3, 3, 2, 2);
        send_request(OP_ROW_SIZE, 6'd0, 11'd2, VALUE_MAX);
        send_request(OP_ROW_SIZE, 6'd1, 11'd0, VALUE_MIN);
        send_request(OP_ROW_SIZE, 6'd2, 11'd2047, 32'h0);
        send_request(OP_COL_SIZE, 6'd0, 11'd3, 32'hFFFF_FFFF);
        send_request(OP_COL_SIZE, 6'd1, 11'd1024, 32'h0);
        send_request(OP_ROW_SIZE, 6'd63, 11'd1024, 32'h0);
        send_request(OP_UNUSED, 6'd63, 11'd2047, 32'hFFFF_FFFF);
        send_request(OP_PIXEL, 6'd0, 11'd0, 32'd5);
        send_request(OP_PIXEL, 6'd0, 11'd0, VALUE_MIN);
        send_request(OP_PIXEL, 6'd0, 11'd0, VALUE_MAX);
        send_request(OP_PIXEL, 6'd0, 11'd0, 32'h0);
        send_request(OP_PIXEL, 6'd0, 11'd0, 32'hFFFF_FFFF);
        send_request(OP_PIXEL, 6'd0, 11'd0, 32'd5);
        send_request(OP_PIXEL, 6'd0, 11'd0, 32'd3);
        send_request(OP_PIXEL, 6'd0, 11'd0, VALUE_MAX);
        send_request(OP_PIXEL, 6'd0, 11'd0, 32'h0);
        send_request(OP_PIXEL, 6'd0, 11'd0, 32'hFFFF_FFFF);
        send_request(OP_PIXEL, 6'd0, 11'd0, VALUE_MIN);
        send_request(OP_PIXEL, 6'd0, 11'd0, VALUE_MIN);
        send_request(OP_PIXEL, 6'd0, 11'd0, 32'd7);
        send_request(OP_PIXEL, 6'd0, 11'd0, VALUE_MAX);
        send_request(OP_PIXEL, 6'd0, 11'd0, VALUE_MAX);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            run_job(phase);
            phase++;
        end

        wait_drained();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
hdl/fmpa_pkg.sv
hdl/fmpa_ram.sv
hdl/fmpa_fifo.sv
hdl/fmpa_front.sv
hdl/fmpa_back.sv
hdl/fractional_max_pool_argmax_2d_core.sv
tb/sv/pool_argmax_checker.sv
tb/sv/testbench.sv
